>>> rtl/sha1_pkg.sv
`default_nettype none

package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] hash_t;

  // Initial hash value; H0 sits at index 0.
  localparam hash_t H_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                              32'hefcdab89, 32'h67452301};

  localparam word_t K_0 = 32'h5a827999;
  localparam word_t K_1 = 32'h6ed9eba1;
  localparam word_t K_2 = 32'h8f1bbcdc;
  localparam word_t K_3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE        = 8'h80;
  localparam logic [6:0] LAST_ROUND      = 7'd79;
  localparam logic [5:0] BLOCK_LAST_BYTE = 6'd63;
  localparam logic [5:0] LEN_START       = 6'd56;
  localparam logic [2:0] LEN_LAST        = 3'd7;
  localparam logic [2:0] LAST_WORD_IDX   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_COMP,
    ST_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_ROUND,
    ENG_ADD
  } eng_state_t;

  // Sequencer to engine commands.
  typedef struct packed {
    logic       shift;   // shift one byte into the block
    logic [7:0] data;
    logic       start;   // begin compressing the block
    logic       reload;  // load initial hash value
  } eng_cmd_t;

endpackage

`default_nettype wire

>>> rtl/sha1_engine.sv
`default_nettype none

// Block register, message schedule and one shared round unit.
module sha1_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sha1_pkg::eng_cmd_t cmd,
  output logic                  done,
  output sha1_pkg::hash_t       hash
);

  sha1_pkg::eng_state_t state, state_next;
  logic [6:0]           round, round_next;
  sha1_pkg::hash_t      hash_next;

  // Word i of the window lives at blk[511-32*i -: 32]; word 0 is the oldest.
  logic [511:0]         blk, blk_next;
  sha1_pkg::word_t      a, b, c, d, e;
  sha1_pkg::word_t      a_next, b_next, c_next, d_next, e_next;

  sha1_pkg::word_t      w0, w2, w8, w13, w_mix, w_sched, wi, f, k, t;

  assign w0  = blk[511:480];
  assign w2  = blk[447:416];
  assign w8  = blk[255:224];
  assign w13 = blk[95:64];
  assign w_mix   = w13 ^ w8 ^ w2 ^ w0;
  assign w_sched = {w_mix[30:0], w_mix[31]};
  // First 16 rounds rotate the block through unchanged.
  assign wi = (round < 7'd16) ? w0 : w_sched;

  always_comb begin
    if (round < 7'd20) begin
      f = d ^ (b & (c ^ d));
      k = sha1_pkg::K_0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1_pkg::K_1;
    end else if (round < 7'd60) begin
      f = (b & c) | (d & (b | c));
      k = sha1_pkg::K_2;
    end else begin
      f = b ^ c ^ d;
      k = sha1_pkg::K_3;
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + wi;

  always_comb begin
    state_next = state;
    round_next = round;
    hash_next  = hash;
    blk_next   = blk;
    a_next     = a;
    b_next     = b;
    c_next     = c;
    d_next     = d;
    e_next     = e;
    done       = 1'b0;
    case (state)
      sha1_pkg::ENG_IDLE: begin
        if (cmd.shift) begin
          blk_next = {blk[503:0], cmd.data};
        end
        if (cmd.reload) begin
          hash_next = sha1_pkg::H_INIT;
        end
        if (cmd.start) begin
          a_next     = hash[0];
          b_next     = hash[1];
          c_next     = hash[2];
          d_next     = hash[3];
          e_next     = hash[4];
          round_next = '0;
          state_next = sha1_pkg::ENG_ROUND;
        end
      end
      sha1_pkg::ENG_ROUND: begin
        blk_next = {blk[479:0], wi};
        a_next   = t;
        b_next   = a;
        c_next   = {b[1:0], b[31:2]};
        d_next   = c;
        e_next   = d;
        if (round == sha1_pkg::LAST_ROUND) begin
          round_next = '0;
          state_next = sha1_pkg::ENG_ADD;
        end else begin
          round_next = round + 7'd1;
        end
      end
      sha1_pkg::ENG_ADD: begin
        hash_next[0] = hash[0] + a;
        hash_next[1] = hash[1] + b;
        hash_next[2] = hash[2] + c;
        hash_next[3] = hash[3] + d;
        hash_next[4] = hash[4] + e;
        done         = 1'b1;
        state_next   = sha1_pkg::ENG_IDLE;
      end
      default: begin
        state_next = sha1_pkg::ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1_pkg::ENG_IDLE;
      round <= '0;
      hash  <= sha1_pkg::H_INIT;
    end else begin
      state <= state_next;
      round <= round_next;
      hash  <= hash_next;
    end
  end

  always_ff @(posedge clk) begin
    blk <= blk_next;
    a   <= a_next;
    b   <= b_next;
    c   <= c_next;
    d   <= d_next;
    e   <= e_next;
  end

endmodule

`default_nettype wire

>>> rtl/sha1_message_hasher_core.sv
// A byte request without end of message is taken in the idle state; a byte that fills
// a block starts a compression. End of message: pad and length bytes one per cycle
// while no compression runs, one or two compressions (80 rounds in one shared round
// unit plus the add), then 5 words, 1 per unstalled cycle. Requests stall while a
// block is compressed, padded or output, so no byte is taken during that work.
// Synchronous active-high rst: initial hash loaded, counters cleared, idle.
`default_nettype none

module sha1_message_hasher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte request channel
  input  wire logic        msg_valid,
  output logic             msg_stall,
  input  wire logic [7:0]  msg_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_message,
  // digest request channel
  output logic             dig_valid,
  input  wire logic        dig_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  // Sequencer state. ret_state is where to go once a compression finishes.
  sha1_pkg::seq_state_t state, state_next;
  sha1_pkg::seq_state_t ret_state, ret_state_next;
  logic [5:0]           bytes, bytes_next;       // bytes in current block, wraps at 64
  logic [63:0]          bit_count, bit_count_next;
  logic [2:0]           len_idx, len_idx_next;   // length byte, MSB first
  logic [2:0]           out_idx, out_idx_next;

  sha1_pkg::eng_cmd_t   cmd;
  logic                 eng_done;
  sha1_pkg::hash_t      hash;
  logic [5:0]           len_base;

  sha1_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .done (eng_done),
    .hash (hash)
  );

  // Length bytes go out big-endian: index 0 picks bits 63:56.
  assign len_base = {~len_idx, 3'b000};

  // Only the idle state takes requests; one item is worked at a time.
  assign msg_stall   = (state != sha1_pkg::ST_IDLE);
  assign dig_valid   = (state == sha1_pkg::ST_OUT);
  // Hash words hold still in the output state, so the mux output is stable.
  assign digest_word = hash[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == sha1_pkg::LAST_WORD_IDX);

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    bytes_next     = bytes;
    bit_count_next = bit_count;
    len_idx_next   = len_idx;
    out_idx_next   = out_idx;
    cmd            = '0;
    case (state)
      sha1_pkg::ST_IDLE: begin
        if (msg_valid) begin
          if (byte_present) begin
            cmd.shift      = 1'b1;
            cmd.data       = msg_byte;
            bytes_next     = bytes + 6'd1;
            bit_count_next = bit_count + 64'd8;
          end
          if (byte_present && bytes == sha1_pkg::BLOCK_LAST_BYTE) begin
            // Block full: compress, then pad if this was the end.
            cmd.start      = 1'b1;
            state_next     = sha1_pkg::ST_COMP;
            ret_state_next = end_of_message ? sha1_pkg::ST_PAD80 : sha1_pkg::ST_IDLE;
          end else if (end_of_message) begin
            state_next = sha1_pkg::ST_PAD80;
          end
        end
      end
      sha1_pkg::ST_PAD80: begin
        cmd.shift  = 1'b1;
        cmd.data   = sha1_pkg::PAD_BYTE;
        bytes_next = bytes + 6'd1;
        if (bytes == sha1_pkg::BLOCK_LAST_BYTE) begin
          cmd.start      = 1'b1;
          state_next     = sha1_pkg::ST_COMP;
          ret_state_next = sha1_pkg::ST_PADZ;
        end else begin
          state_next = sha1_pkg::ST_PADZ;
        end
      end
      sha1_pkg::ST_PADZ: begin
        // Zero fill up to the length field; may spill into an extra block.
        if (bytes == sha1_pkg::LEN_START) begin
          len_idx_next = '0;
          state_next   = sha1_pkg::ST_PADLEN;
        end else begin
          cmd.shift  = 1'b1;
          cmd.data   = 8'h00;
          bytes_next = bytes + 6'd1;
          if (bytes == sha1_pkg::BLOCK_LAST_BYTE) begin
            cmd.start      = 1'b1;
            state_next     = sha1_pkg::ST_COMP;
            ret_state_next = sha1_pkg::ST_PADZ;
          end
        end
      end
      sha1_pkg::ST_PADLEN: begin
        cmd.shift    = 1'b1;
        cmd.data     = bit_count[len_base +: 8];
        bytes_next   = bytes + 6'd1;
        len_idx_next = len_idx + 3'd1;
        if (len_idx == sha1_pkg::LEN_LAST) begin
          cmd.start      = 1'b1;
          out_idx_next   = '0;
          state_next     = sha1_pkg::ST_COMP;
          ret_state_next = sha1_pkg::ST_OUT;
        end
      end
      sha1_pkg::ST_COMP: begin
        if (eng_done) begin
          state_next = ret_state;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (!dig_stall) begin
          if (out_idx == sha1_pkg::LAST_WORD_IDX) begin
            // Digest delivered: start a fresh message.
            cmd.reload     = 1'b1;
            out_idx_next   = '0;
            bytes_next     = '0;
            bit_count_next = '0;
            state_next     = sha1_pkg::ST_IDLE;
          end else begin
            out_idx_next = out_idx + 3'd1;
          end
        end
      end
      default: begin
        state_next = sha1_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha1_pkg::ST_IDLE;
      ret_state <= sha1_pkg::ST_IDLE;
      bytes     <= '0;
      bit_count <= '0;
      len_idx   <= '0;
      out_idx   <= '0;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      bytes     <= bytes_next;
      bit_count <= bit_count_next;
      len_idx   <= len_idx_next;
      out_idx   <= out_idx_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sha1_checker.sv
`default_nettype none

module sha1_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        msg_valid,
  input wire logic        msg_stall,
  input wire logic        end_of_message,
  input wire logic        dig_valid,
  input wire logic        dig_stall,
  input wire logic [31:0] digest_word,
  input wire logic [2:0]  word_index,
  input wire logic        last_word
);

  // No new request is taken while the digest is going out.
  a_busy_on_out: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> msg_stall)
    else $error("byte request open while digest pending");

  // End of message always leads into padding work.
  a_busy_after_end: assert property (@(posedge clk) disable iff (rst)
    msg_valid && !msg_stall && end_of_message |=> msg_stall)
    else $error("not busy after end of message");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (last_word == (word_index == 3'd4)))
    else $error("last_word does not match word_index");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_stall && !last_word |=>
      dig_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest words out of order");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_stall |=>
      dig_valid && $stable(digest_word) && $stable(word_index))
    else $error("stalled digest word changed");

endmodule

bind sha1_message_hasher_core sha1_checker u_sha1_checker (.*);

`default_nettype wire
